[rtl/lhs_pkg.sv]
// Shared constants, types and helpers for the letter histogram sorter.
package lhs_pkg;

	localparam int COUNT_BITS  = 24;
	localparam int COUNT_W     = 24;
	localparam int NUM_LETTERS = 26;
	localparam int IDX_W       = $clog2(NUM_LETTERS);

	localparam logic [7:0] CHAR_LA = 8'h61;
	localparam logic [7:0] CHAR_LZ = 8'h7A;
	localparam logic [7:0] CHAR_UA = 8'h41;
	localparam logic [7:0] CHAR_UZ = 8'h5A;
	localparam logic [7:0] CHAR_NL = 8'h0A;

	localparam logic CMD_COUNT  = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	localparam logic [1:0] ORD_ASC   = 2'd0;
	localparam logic [1:0] ORD_DESC  = 2'd1;
	localparam logic [1:0] ORD_TOTAL = 2'd2;

	typedef logic [COUNT_BITS-1:0] bin_t;
	typedef logic [IDX_W-1:0]      idx_t;

	localparam idx_t LAST_IDX  = IDX_W'(NUM_LETTERS - 1);
	localparam bin_t COUNT_MAX = '1;

	typedef struct packed {
		logic       command;
		logic [7:0] text_byte;
	} lhs_in_t;

	typedef struct packed {
		logic [1:0]         order;
		logic [4:0]         letter;
		logic [COUNT_W-1:0] count;
		logic               last;
	} lhs_out_t;

	typedef struct packed {
		logic desc;
		idx_t addr;
	} lhs_sidx_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} lhs_rank_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RANK,
		ST_IDX,
		ST_BIN,
		ST_OUT,
		ST_TOTAL
	} lhs_state_t;

	function automatic bin_t sat_inc(input bin_t v);
		return (v == COUNT_MAX) ? v : v + 1'b1;
	endfunction

endpackage

[rtl/lhs_bin_ram.sv]
// Letter bin memory: two registered read ports, one write port, per-entry valid bits.
module lhs_bin_ram import lhs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  idx_t addr_a,
	input  idx_t addr_b,
	output bin_t rd_a,
	output bin_t rd_b,
	input  logic we,
	input  idx_t waddr,
	input  bin_t wdata,
	input  logic clear
);

	bin_t                   mem [NUM_LETTERS];
	logic [NUM_LETTERS-1:0] valid_q;
	bin_t                   mem_a_q;
	bin_t                   mem_b_q;
	logic                   ok_a_q;
	logic                   ok_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		mem_a_q <= mem[addr_a];
		mem_b_q <= mem[addr_b];
	end

	// entry not yet written since the last clear reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ok_a_q  <= 1'b0;
			ok_b_q  <= 1'b0;
		end else begin
			ok_a_q <= valid_q[addr_a];
			ok_b_q <= valid_q[addr_b];
			if (clear) begin
				valid_q <= '0;
			end else if (we) begin
				valid_q[waddr] <= 1'b1;
			end
		end
	end

	assign rd_a = ok_a_q ? mem_a_q : '0;
	assign rd_b = ok_b_q ? mem_b_q : '0;

endmodule

[rtl/lhs_rank.sv]
// Rank engine: sweeps all bin pairs, writes ascending and descending order memories.
module lhs_rank import lhs_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  bin_t           rd_a,
	input  bin_t           rd_b,
	output idx_t           addr_a,
	output idx_t           addr_b,
	input  lhs_sidx_req_t  sidx_req,
	output idx_t           sidx_data,
	output lhs_rank_stat_t stat
);

	idx_t sidx_asc  [NUM_LETTERS];
	idx_t sidx_desc [NUM_LETTERS];

	logic run_q;
	idx_t i_q;
	idx_t j_q;
	logic valid_s1;
	idx_t i_s1;
	idx_t j_s1;
	idx_t pos_asc_q;
	idx_t pos_desc_q;
	idx_t pos_asc_d;
	idx_t pos_desc_d;
	idx_t asc_rd_q;
	idx_t desc_rd_q;
	logic desc_sel_q;
	logic tie;
	logic inc_asc;
	logic inc_desc;
	logic row_end;

	assign addr_a = i_q;
	assign addr_b = j_q;

	// rd_a holds bin i, rd_b bin j; ties go to the lower letter
	always_comb begin
		tie        = (rd_b == rd_a) && (j_s1 < i_s1);
		inc_asc    = (rd_b < rd_a) || tie;
		inc_desc   = (rd_b > rd_a) || tie;
		pos_asc_d  = pos_asc_q + idx_t'(inc_asc);
		pos_desc_d = pos_desc_q + idx_t'(inc_desc);
		row_end    = valid_s1 && (j_s1 == LAST_IDX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q      <= 1'b0;
			i_q        <= '0;
			j_q        <= '0;
			valid_s1   <= 1'b0;
			pos_asc_q  <= '0;
			pos_desc_q <= '0;
		end else begin
			if (start) begin
				run_q <= 1'b1;
				i_q   <= '0;
				j_q   <= '0;
			end else if (run_q) begin
				if (j_q == LAST_IDX) begin
					j_q <= '0;
					if (i_q == LAST_IDX) begin
						run_q <= 1'b0;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
			valid_s1 <= run_q;
			if (row_end) begin
				pos_asc_q  <= '0;
				pos_desc_q <= '0;
			end else if (valid_s1) begin
				pos_asc_q  <= pos_asc_d;
				pos_desc_q <= pos_desc_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		i_s1 <= i_q;
		j_s1 <= j_q;
		if (row_end) begin
			sidx_asc[pos_asc_d]   <= i_s1;
			sidx_desc[pos_desc_d] <= i_s1;
		end
		asc_rd_q   <= sidx_asc[sidx_req.addr];
		desc_rd_q  <= sidx_desc[sidx_req.addr];
		desc_sel_q <= sidx_req.desc;
	end

	assign sidx_data = desc_sel_q ? desc_rd_q : asc_rd_q;
	assign stat.busy = run_q || valid_s1;
	assign stat.done = row_end && (i_s1 == LAST_IDX);

endmodule

[rtl/letter_histogram_sort.sv]
// Top level of the letter histogram sorter: count path, dump sequencer, output register.
//
// Usage
//   Input channel (item_valid / item_stall / item): each transfer carries a command
//   and a text byte. A count command adds the byte to the running total (newline
//   is dropped) and, for a letter of either case, bumps that letter's bin. Count
//   transfers are taken one per cycle while the block is idle; the bin update is
//   a read-modify-write on the bin RAM with forwarding from the previous write.
//   A finish command stalls the input for the whole dump. A ranking sweep compares
//   every bin against every other over the two RAM read ports. Then 53 results
//   leave on the result channel (result_valid / result_stall / result): 26
//   ascending, 26 descending, then the total with last set. Each list entry
//   passes through an order memory read, a bin read and an output load, and the
//   total is then loaded from the total register.
//   After the total is loaded the bins and the total read as zero again and the
//   input reopens, even while the total still waits in the output register.
//   A stalled result holds in the output register and the dump waits behind it.
//   Reset clears the bins (valid bits), the total and all control state at once:
//   no clearing pass is needed.
module letter_histogram_sort import lhs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_stall,
	input  lhs_in_t  item,
	output logic     result_valid,
	input  logic     result_stall,
	output lhs_out_t result
);

	lhs_state_t     state_q;
	lhs_state_t     state_d;
	logic           item_acc;
	logic           is_lower;
	logic           is_upper;
	idx_t           byte_idx;

	// count pipeline
	logic           cnt_valid_s1;
	idx_t           cnt_idx_s1;
	logic           fwd_valid_q;
	idx_t           fwd_idx_q;
	bin_t           fwd_data_q;
	bin_t           cnt_old;
	bin_t           cnt_new;
	bin_t           total_q;

	// bin RAM ports
	idx_t           addr_a;
	idx_t           addr_b;
	bin_t           rd_a;
	bin_t           rd_b;
	logic           clear_bins;

	// rank engine and dump sequencing
	logic           rank_start;
	idx_t           rank_addr_a;
	lhs_rank_stat_t rank_stat;
	lhs_sidx_req_t  sidx_req;
	idx_t           sidx_data;
	idx_t           k_q;
	logic           list_q;
	idx_t           letter_q;

	// output register
	logic           out_valid_q;
	lhs_out_t       out_q;
	logic           out_free;
	logic           out_load_entry;
	logic           out_load_total;

	assign item_acc     = item_valid && !item_stall;
	assign out_free     = !out_valid_q || !result_stall;
	assign result_valid = out_valid_q;
	assign result       = out_q;
	assign clear_bins   = out_load_total;
	assign sidx_req     = '{desc: list_q, addr: k_q};

	always_comb begin
		is_lower = item.text_byte inside {[CHAR_LA:CHAR_LZ]};
		is_upper = item.text_byte inside {[CHAR_UA:CHAR_UZ]};
		if (is_lower) begin
			byte_idx = IDX_W'(item.text_byte - CHAR_LA);
		end else if (is_upper) begin
			byte_idx = IDX_W'(item.text_byte - CHAR_UA);
		end else begin
			byte_idx = '0;
		end
	end

	// forward the last write: the RAM read taken at the same edge saw the old value
	always_comb begin
		cnt_old = (fwd_valid_q && (fwd_idx_q == cnt_idx_s1)) ? fwd_data_q : rd_a;
		cnt_new = sat_inc(cnt_old);
	end

	lhs_bin_ram u_bin_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.addr_a (addr_a),
		.addr_b (addr_b),
		.rd_a   (rd_a),
		.rd_b   (rd_b),
		.we     (cnt_valid_s1),
		.waddr  (cnt_idx_s1),
		.wdata  (cnt_new),
		.clear  (clear_bins)
	);

	lhs_rank u_rank (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (rank_start),
		.rd_a      (rd_a),
		.rd_b      (rd_b),
		.addr_a    (rank_addr_a),
		.addr_b    (addr_b),
		.sidx_req  (sidx_req),
		.sidx_data (sidx_data),
		.stat      (rank_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// port A serves the count path when idle, the ranker, then the dump reads
	always_comb begin
		state_d        = state_q;
		item_stall     = 1'b1;
		rank_start     = 1'b0;
		out_load_entry = 1'b0;
		out_load_total = 1'b0;
		addr_a         = letter_q;
		case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				addr_a     = byte_idx;
				if (item_valid && item.command == CMD_FINISH) begin
					rank_start = 1'b1;
					state_d    = ST_RANK;
				end
			end
			ST_RANK: begin
				addr_a = rank_addr_a;
				if (rank_stat.done) begin
					state_d = ST_IDX;
				end
			end
			ST_IDX: begin
				state_d = ST_BIN;
			end
			ST_BIN: begin
				addr_a  = sidx_data;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					out_load_entry = 1'b1;
					if (k_q == LAST_IDX && list_q) begin
						state_d = ST_TOTAL;
					end else begin
						state_d = ST_IDX;
					end
				end
			end
			ST_TOTAL: begin
				if (out_free) begin
					out_load_total = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_valid_s1 <= 1'b0;
			fwd_valid_q  <= 1'b0;
			total_q      <= '0;
			k_q          <= '0;
			list_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			cnt_valid_s1 <= item_acc && (item.command == CMD_COUNT) && (is_lower || is_upper);
			fwd_valid_q  <= cnt_valid_s1;
			if (out_load_total) begin
				total_q <= '0;
			end else if (item_acc && item.command == CMD_COUNT && item.text_byte != CHAR_NL) begin
				total_q <= sat_inc(total_q);
			end
			if (state_q == ST_RANK && rank_stat.done) begin
				k_q    <= '0;
				list_q <= 1'b0;
			end else if (out_load_entry) begin
				if (k_q == LAST_IDX) begin
					k_q    <= '0;
					list_q <= 1'b1;
				end else begin
					k_q <= k_q + 1'b1;
				end
			end
			if (out_load_entry || out_load_total) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cnt_idx_s1 <= byte_idx;
		fwd_idx_q  <= cnt_idx_s1;
		fwd_data_q <= cnt_new;
		if (state_q == ST_BIN) begin
			letter_q <= sidx_data;
		end
		if (out_load_entry) begin
			out_q.order  <= list_q ? ORD_DESC : ORD_ASC;
			out_q.letter <= 5'(letter_q);
			out_q.count  <= COUNT_W'(rd_a);
			out_q.last   <= 1'b0;
		end else if (out_load_total) begin
			out_q.order  <= ORD_TOTAL;
			out_q.letter <= '0;
			out_q.count  <= COUNT_W'(total_q);
			out_q.last   <= 1'b1;
		end
	end

	// a bin write belongs to a byte taken while idle
	a_write_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_valid_s1 |-> $past(state_q) == ST_IDLE)
		else $error("bin write without a preceding idle count transfer");

	// the input stays closed while the ranker runs
	a_no_input_in_rank: assert property (@(posedge clk) disable iff (!arst_n)
		rank_stat.busy |-> item_stall)
		else $error("input open during ranking");

	// the ranker finishes only inside the ranking state
	a_done_in_rank: assert property (@(posedge clk) disable iff (!arst_n)
		rank_stat.done |-> state_q == ST_RANK)
		else $error("rank done outside ranking");

	// a fresh result never replaces one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load_entry || out_load_total) |-> (!out_valid_q || !result_stall))
		else $error("output register overwritten under stall");

endmodule
